// ===== rtl/sleep_wakeup_timer_table_macros.svh =====
// Assertion helpers used by swt_dpath.
`ifndef SLEEP_WAKEUP_TIMER_TABLE_MACROS_SVH
`define SLEEP_WAKEUP_TIMER_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sleep timer table check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sleep timer table check failed");

`endif

// ===== rtl/swt_pkg.sv =====
package swt_pkg;

	localparam logic CMD_SLEEP = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic [1:0] KIND_WOKEN   = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_ACCEPT  = 2'd2;
	localparam logic [1:0] KIND_REJECT  = 2'd3;

	localparam int          APB_ADDR_W  = 3;
	localparam logic [APB_ADDR_W-1:0] REG_PREEMPT = 3'd0;

	typedef struct packed {
		logic        command;
		logic [7:0]  thread_id;
		logic [15:0] delay_ticks;
		logic        idle_mode;
		logic        future_interrupts;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] woken_id;
		logic       yield_request;
		logic       timer_disable;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic take_sleep;
		logic take_tick;
		logic sleep_done;
		logic step;
		logic summary;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_cmd;
		logic empty;
		logic due;
		logic last_entry;
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== rtl/swt_ctrl.sv =====
module swt_ctrl
	import swt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SLEEP = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_SUM   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (sts.in_cmd == CMD_TICK) begin
						cmd.take_tick = 1'b1;
						state_d = sts.empty ? ST_SUM : ST_SCAN;
					end else begin
						cmd.take_sleep = 1'b1;
						state_d = ST_SLEEP;
					end
				end
			end
			ST_SLEEP: begin
				if (sts.out_free) begin
					cmd.sleep_done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (!sts.due || sts.out_free) begin
					cmd.step = 1'b1;
					if (sts.last_entry) begin
						state_d = ST_SUM;
					end
				end
			end
			ST_SUM: begin
				if (sts.out_free) begin
					cmd.summary = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/swt_dpath.sv =====
module swt_dpath
	import swt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
)
(
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  logic     preempt,
	input  ctl_cmd_t cmd,
	output ctl_sts_t sts,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output rsp_t     rsp
);

	`include "sleep_wakeup_timer_table_macros.svh"

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [31:0]      tick_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] keep_q;
	logic             woken_q;
	logic             idle_q;
	logic             fut_q;
	logic [7:0]       thread_q;
	logic [15:0]      delay_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [7:0]  thread_mem_q   [TABLE_ENTRIES];
	logic [31:0] deadline_mem_q [TABLE_ENTRIES];
	logic [7:0]  rd_thread_q;
	logic [31:0] rd_deadline_q;

	logic [CNT_W-1:0] idx_next;
	logic [31:0]      diff;
	logic             full;
	logic             due;
	logic             last_entry;
	logic             out_free;
	logic             quiet;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [7:0]       wr_thread;
	logic [31:0]      wr_deadline;
	logic             load_out;
	rsp_t             rsp_d;

	assign idx_next   = CNT_W'(idx_q + CNT_ONE);
	assign diff       = tick_q - rd_deadline_q;
	assign due        = !diff[31];
	assign full       = (count_q == CNT_FULL);
	assign last_entry = (idx_next == count_q);
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign quiet      = idle_q && !woken_q && (keep_q == '0);

	assign sts.in_cmd     = req.command;
	assign sts.empty      = (count_q == '0);
	assign sts.due        = due;
	assign sts.last_entry = last_entry;
	assign sts.out_free   = out_free;

	assign rd_en   = cmd.take_tick || (cmd.step && !last_entry);
	assign rd_addr = cmd.take_tick ? '0 : idx_next[IDX_W-1:0];

	assign wr_en       = (cmd.sleep_done && !full) || (cmd.step && !due);
	assign wr_addr     = cmd.sleep_done ? count_q[IDX_W-1:0] : keep_q[IDX_W-1:0];
	assign wr_thread   = cmd.sleep_done ? thread_q : rd_thread_q;
	assign wr_deadline = cmd.sleep_done ? (tick_q + {16'b0, delay_q}) : rd_deadline_q;

	always_comb begin
		rsp_d = '0;
		load_out = 1'b0;
		if (cmd.sleep_done) begin
			load_out = 1'b1;
			rsp_d.kind = full ? KIND_REJECT : KIND_ACCEPT;
			rsp_d.last = 1'b1;
		end else if (cmd.step && due) begin
			load_out = 1'b1;
			rsp_d.kind = KIND_WOKEN;
			rsp_d.woken_id = rd_thread_q;
		end else if (cmd.summary) begin
			load_out = 1'b1;
			rsp_d.kind = KIND_SUMMARY;
			rsp_d.yield_request = !quiet && preempt;
			rsp_d.timer_disable = quiet && !fut_q;
			rsp_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			thread_mem_q[wr_addr]   <= wr_thread;
			deadline_mem_q[wr_addr] <= wr_deadline;
		end
		if (rd_en) begin
			rd_thread_q   <= thread_mem_q[rd_addr];
			rd_deadline_q <= deadline_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_sleep) begin
			thread_q <= req.thread_id;
			delay_q  <= req.delay_ticks;
		end
		if (cmd.take_tick) begin
			idle_q <= req.idle_mode;
			fut_q  <= req.future_interrupts;
		end
		if (load_out) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			keep_q      <= '0;
			woken_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.take_tick) begin
				tick_q  <= tick_q + 32'd1;
				idx_q   <= '0;
				keep_q  <= '0;
				woken_q <= 1'b0;
			end
			if (cmd.step) begin
				idx_q <= idx_next;
				if (due) begin
					woken_q <= 1'b1;
				end else begin
					keep_q <= CNT_W'(keep_q + CNT_ONE);
				end
			end
			if (cmd.sleep_done && !full) begin
				count_q <= CNT_W'(count_q + CNT_ONE);
			end
			if (cmd.summary) begin
				count_q <= keep_q;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SWT_ASSERT_SAME(a_count_in_range, 1'b1, count_q <= CNT_FULL)
	`SWT_ASSERT_SAME(a_keep_behind_scan, cmd.step, keep_q <= idx_q && idx_q < count_q)
	`SWT_ASSERT_SAME(a_load_into_free_slot, load_out, out_free)
	`SWT_ASSERT_NEXT(a_summary_sets_count, cmd.summary, count_q == $past(keep_q))

endmodule

// ===== rtl/sleep_wakeup_timer_table.sv =====
// Sleep timer table: a sleep request appends a thread id with deadline
// tick count plus delay unless the table is full, and returns one result.
// A tick advances the counter and then scans the used entries one per clock
// unless a woken entry waits for the output register, limited by the single
// read port of the entry memory; it returns one result per woken thread and
// a final summary. One request is handled at a time, and the next request
// transfer can occur while the last result still waits in the output register.
// There is no clearing pass after reset; the preempt_enable register sits at
// byte address 0.
module sleep_wakeup_timer_table
	import swt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;
	logic     preempt_q;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_PREEMPT) ? {31'b0, preempt_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preempt_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr == REG_PREEMPT) begin
			preempt_q <= pwdata[0];
		end
	end

	swt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	swt_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.preempt   (preempt_q),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== test/sleep_wakeup_timer_table_test.sv =====
module sleep_wakeup_timer_table_test
	import swt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_SIZE = 16;
	localparam int MAX_REPORTS = 10;

	class sleep_table_scoreboard;
		logic [31:0] ticks;
		logic [7:0] ids[$];
		logic [31:0] deadlines[$];
		logic preempt;
		rsp_t pending_results[$];
		int errors;

		function new();
			ticks = '0;
			preempt = 1'b1;
			errors = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void note_request(req_t r);
			logic [31:0] age;
			logic [31:0] deadline;
			logic [7:0] kept_ids[$];
			logic [31:0] kept_deadlines[$];
			bit woke;
			rsp_t res;
			woke = 1'b0;
			if (r.command == CMD_SLEEP) begin
				res = '0;
				res.last = 1'b1;
				if (ids.size() >= TABLE_SIZE) begin
					res.kind = KIND_REJECT;
				end else begin
					deadline = ticks + {16'b0, r.delay_ticks};
					ids = {ids, r.thread_id};
					deadlines = {deadlines, deadline};
					res.kind = KIND_ACCEPT;
				end
				pending_results = {pending_results, res};
			end else begin
				ticks = ticks + 32'd1;
				foreach (ids[i]) begin
					age = ticks - deadlines[i];
					if (!age[31]) begin
						res = '0;
						res.kind = KIND_WOKEN;
						res.woken_id = ids[i];
						pending_results = {pending_results, res};
						woke = 1'b1;
					end else begin
						kept_ids = {kept_ids, ids[i]};
						kept_deadlines = {kept_deadlines, deadlines[i]};
					end
				end
				ids = kept_ids;
				deadlines = kept_deadlines;
				res = '0;
				res.kind = KIND_SUMMARY;
				res.last = 1'b1;
				if (r.idle_mode && !woke && ids.size() == 0) begin
					res.timer_disable = !r.future_interrupts;
				end else begin
					res.yield_request = preempt;
				end
				pending_results = {pending_results, res};
			end
		endfunction

		function void report(string what, rsp_t want, rsp_t got);
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("%0t %s: expected kind=%0d id=%0h yield=%0b disable=%0b last=%0b",
					$realtime, what, want.kind, want.woken_id, want.yield_request,
					want.timer_disable, want.last);
				$display("%0t %s: got kind=%0d id=%0h yield=%0b disable=%0b last=%0b",
					$realtime, what, got.kind, got.woken_id,
					got.yield_request, got.timer_disable, got.last);
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending_results.size() == 0) begin
				report("unexpected result", 'x, got);
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.woken_id !== want.woken_id ||
						got.yield_request !== want.yield_request ||
						got.timer_disable !== want.timer_disable ||
						got.last !== want.last) begin
					report("mismatch", want, got);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	sleep_table_scoreboard table_model;
	bit idle_on;
	int hold_off_cycles;
	int tick_pct[4] = '{35, 50, 40, 65};

	sleep_wakeup_timer_table #(.TABLE_ENTRIES(TABLE_SIZE)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic req_t make_sleep(logic [7:0] id, logic [15:0] delay);
		req_t r;
		r = '0;
		r.command = CMD_SLEEP;
		r.thread_id = id;
		r.delay_ticks = delay;
		return r;
	endfunction

	function automatic req_t make_tick(logic idle, logic future);
		req_t r;
		r = '0;
		r.command = CMD_TICK;
		r.idle_mode = idle;
		r.future_interrupts = future;
		return r;
	endfunction

	function automatic req_t random_request(int pct, bit wide_delay);
		req_t r;
		r.command = ($urandom_range(99, 0) < pct) ? CMD_TICK : CMD_SLEEP;
		r.thread_id = 8'($urandom_range(255, 0));
		if (wide_delay && $urandom_range(7, 0) == 0) begin
			r.delay_ticks = 16'($urandom_range(65535, 0));
		end else begin
			r.delay_ticks = 16'($urandom_range(24, 0));
		end
		r.idle_mode = 1'($urandom_range(1, 0));
		r.future_interrupts = 1'($urandom_range(1, 0));
		return r;
	endfunction

	// Valid stays high between back-to-back transfers.
	task automatic send_req(input req_t item);
		int gap;
		gap = idle_on ? $urandom_range(12, 0) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		table_model.note_request(item);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (table_model.pending() != 0);
	endtask

	task automatic write_preempt(input logic value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_PREEMPT;
		pwdata <= {31'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		table_model.preempt = value;
	endtask

	initial begin
		int gap;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = idle_on ? $urandom_range(12, 0) : 0;
			if (hold_off_cycles > 0) begin
				gap = hold_off_cycles;
				hold_off_cycles = 0;
			end
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			table_model.check_result(rsp);
		end
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		table_model = new();
		idle_on = 1'b1;
		hold_off_cycles = 0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: idle ticks with and without pending interrupts, then a busy tick.
		send_req(make_tick(1'b1, 1'b0));
		send_req(make_tick(1'b1, 1'b1));
		send_req(make_tick(1'b0, 1'b1));
		send_req(make_sleep(8'h00, 16'd0));
		send_req(make_sleep(8'hff, 16'd1));
		for (int i = 2; i < TABLE_SIZE; i++) begin
			send_req(make_sleep(8'(i * 37), 16'(i % 3)));
		end
		send_req(make_sleep(8'h5a, 16'd0));
		send_req(make_tick(1'b1, 1'b0));
		send_req(make_tick(1'b0, 1'b0));
		send_req(make_tick(1'b1, 1'b1));
		send_req(make_tick(1'b1, 1'b0));
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			write_preempt(phase[0]);
			idle_on = (phase != 0);
			if (phase == 3) begin
				send_req(make_sleep(8'($urandom_range(255, 0)), 16'hffff));
				send_req(make_sleep(8'($urandom_range(255, 0)), 16'h8000));
			end
			for (int n = 0; n < 60; n++) begin
				if (phase == 1 && n == 30) begin
					drain();
				end
				if (phase == 2 && n == 10) begin
					hold_off_cycles = 200;
				end
				send_req(random_request(tick_pct[phase], phase == 3));
			end
			drain();
		end

		repeat (30) @(posedge clk);
		if (table_model.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sleep_wakeup_timer_table.f =====
+incdir+rtl
rtl/swt_pkg.sv
rtl/swt_ctrl.sv
rtl/swt_dpath.sv
rtl/sleep_wakeup_timer_table.sv
test/sleep_wakeup_timer_table_test.sv
